FILE: design/rma_pkg.sv
// Package for the rotation matrix accumulator: action codes, CORDIC angle table.
// No dependencies.
`default_nettype none
package rma_pkg;
    localparam logic [2:0] ACT_IDENT  = 3'd0;
    localparam logic [2:0] ACT_ROT_X  = 3'd1;
    localparam logic [2:0] ACT_ROT_Y  = 3'd2;
    localparam logic [2:0] ACT_ROT_Z  = 3'd3;
    localparam logic [2:0] ACT_MUL    = 3'd4;
    localparam logic [2:0] ACT_TRANS  = 3'd5;

    // atan(2^-i), 2^32 units per turn
    function automatic logic [29:0] atan_units(input logic [5:0] i);
        case (i)
            6'd0: atan_units = 30'd536870912;
            6'd1: atan_units = 30'd316933406;
            6'd2: atan_units = 30'd167458907;
            6'd3: atan_units = 30'd85004756;
            6'd4: atan_units = 30'd42667331;
            6'd5: atan_units = 30'd21354465;
            6'd6: atan_units = 30'd10679838;
            6'd7: atan_units = 30'd5340245;
            6'd8: atan_units = 30'd2670163;
            6'd9: atan_units = 30'd1335087;
            6'd10: atan_units = 30'd667544;
            6'd11: atan_units = 30'd333772;
            6'd12: atan_units = 30'd166886;
            6'd13: atan_units = 30'd83443;
            6'd14: atan_units = 30'd41722;
            6'd15: atan_units = 30'd20861;
            6'd16: atan_units = 30'd10430;
            6'd17: atan_units = 30'd5215;
            6'd18: atan_units = 30'd2608;
            6'd19: atan_units = 30'd1304;
            6'd20: atan_units = 30'd652;
            6'd21: atan_units = 30'd326;
            6'd22: atan_units = 30'd163;
            6'd23: atan_units = 30'd81;
            6'd24: atan_units = 30'd41;
            6'd25: atan_units = 30'd20;
            6'd26: atan_units = 30'd10;
            6'd27: atan_units = 30'd5;
            6'd28: atan_units = 30'd3;
            6'd29: atan_units = 30'd1;
            6'd30: atan_units = 30'd1;
            default: atan_units = 30'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

FILE: design/rma_cordic.sv
// Iterative CORDIC sine/cosine, one step per cycle, Q2.(W-2) outputs.
// Depends on rma_pkg.
`default_nettype none
module rma_cordic import rma_pkg::*; #(
    parameter int W = 32,
    parameter int STEPS = 32,
    parameter logic [63:0] GAIN = 64'd0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [31:0]   i_angle,
    output logic               o_done,
    output logic signed [W-1:0] o_sin,
    output logic signed [W-1:0] o_cos
);
    localparam int SH = 62 - (W - 2);
    localparam logic signed [65:0] ONE = 66'sd1 <<< (62 - SH);

    logic signed [65:0] r_x, r_y, r_z;
    logic [5:0] r_i;
    logic r_busy, r_flip;
    logic [31:0] a;
    logic signed [65:0] dx, dy, at, xr, yr;

    assign a = i_angle + ((i_angle[31] ^ i_angle[30]) ? 32'h8000_0000 : 32'd0);
    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = {36'd0, atan_units(r_i)};

    function automatic logic signed [65:0] to_entry(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (SH > 0) ? ((v + (66'sd1 <<< (SH - 1))) >>> SH) : v;
        if (t > ONE) t = ONE;
        if (t < -ONE) t = -ONE;
        return t;
    endfunction

    assign xr = to_entry(r_x);
    assign yr = to_entry(r_y);

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_flip <= i_angle[31] ^ i_angle[30];
            r_x <= $signed({2'b00, GAIN});
            r_y <= '0;
            r_z <= {{34{a[31]}}, a};
            r_i <= '0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
            end
            r_i <= r_i + 6'd1;
            if (r_i == 6'(STEPS - 1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    // rounding and flip done on the final values
    assign o_cos = W'(r_flip ? -xr : xr);
    assign o_sin = W'(r_flip ? -yr : yr);
endmodule
`default_nettype wire

FILE: design/rotation_matrix_accumulator.sv
// Rotation matrix accumulator top: 9-entry matrix memory, shared MAC, CORDIC.
// Depends on rma_pkg and rma_cordic.
// One request at a time; entry copies pass through the registered memory read and
// products through the registered multiplier.
// Reset loads the identity, input stalled meanwhile.
`default_nettype none
module rotation_matrix_accumulator import rma_pkg::*; #(
    parameter int ENTRY_WIDTH = 32,
    parameter int CORDIC_STEPS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_action,
    input  wire logic signed [31:0] i_angle,
    input  wire logic signed [31:0] i_op_r0c0, i_op_r0c1, i_op_r0c2,
    input  wire logic signed [31:0] i_op_r1c0, i_op_r1c1, i_op_r1c2,
    input  wire logic signed [31:0] i_op_r2c0, i_op_r2c1, i_op_r2c2,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_out_r0c0, o_out_r0c1, o_out_r0c2,
    output logic signed [31:0] o_out_r1c0, o_out_r1c1, o_out_r1c2,
    output logic signed [31:0] o_out_r2c0, o_out_r2c1, o_out_r2c2
);
    localparam int W = ENTRY_WIDTH;
    localparam int F = W - 2;
    localparam int AW = 2 * W + 4;

    // inverse CORDIC gain constant, elaboration time
    function automatic logic [63:0] mq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return p[125:62];
    endfunction
    function automatic logic [63:0] calc_gain();
        logic [63:0] g, y, t;
        g = 64'd1 << 62; y = 64'h2666666666666666;
        for (int i = 0; i < CORDIC_STEPS; i++) if (2 * i < 64) g = g + (g >> (2 * i));
        for (int k = 0; k < 8; k++) begin
            t = mq(g, mq(y, y));
            y = mq(y, (64'd3 << 62) - t) >> 1;
        end
        return y;
    endfunction
    localparam logic [63:0] GAIN = calc_gain();
    localparam logic signed [W-1:0] EMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] EMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONEV = W'(1) << F;

    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_COR = 4'd2, S_RD = 4'd3,
        S_MAC = 4'd4, S_WB = 4'd5, S_TR = 4'd6, S_OUT = 4'd7, S_HOLD = 4'd8,
        S_CPY = 4'd9;

    // matrix memory and result scratch
    logic signed [W-1:0] mem [9];
    logic signed [W-1:0] r_rd;
    logic [3:0] r_ra, r_wa;
    logic r_we;
    logic signed [W-1:0] r_wd;
    logic signed [W-1:0] r_res [9];
    logic signed [W-1:0] r_row;
    logic signed [W-1:0] r_b [9];

    logic [3:0] r_st;
    logic [2:0] r_act;
    logic [31:0] r_angle;
    logic [3:0] r_k;
    logic [1:0] r_t;
    logic [1:0] r_m;
    logic r_cstart;
    logic cdone;
    logic signed [W-1:0] csin, ccos, r_s, r_c;
    logic signed [AW-1:0] r_acc;
    logic signed [W-1:0] r_ma, r_mb;
    logic r_mv;
    logic signed [2*W-1:0] prod;

    function automatic logic signed [W-1:0] sat_in(input logic signed [31:0] f);
        logic signed [64:0] v;
        v = 65'(f);
        if (v > 65'(EMAX)) v = 65'(EMAX);
        if (v < 65'(EMIN)) v = 65'(EMIN);
        return W'(v);
    endfunction

    function automatic logic signed [W-1:0] fin(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        t = (a + (AW'(1) <<< (F - 1))) >>> F;
        if (t > AW'(EMAX)) return EMAX;
        if (t < AW'(EMIN)) return EMIN;
        return W'(t);
    endfunction

    rma_cordic #(.W(W), .STEPS(CORDIC_STEPS), .GAIN(GAIN)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_cstart), .i_angle(r_angle),
        .o_done(cdone), .o_sin(csin), .o_cos(ccos));

    // rows p,q for the rotate actions; row index for target entry k
    logic [1:0] p, q, ri, ci, term;
    always_comb begin
        case (r_act)
            ACT_ROT_X: begin p = 2'd1; q = 2'd2; end
            ACT_ROT_Y: begin p = 2'd2; q = 2'd0; end
            default:   begin p = 2'd0; q = 2'd1; end
        endcase
    end
    assign ri = (r_k >= 4'd6) ? 2'd2 : (r_k >= 4'd3) ? 2'd1 : 2'd0;
    assign ci = 2'(r_k - 4'(ri) * 4'd3);
    assign term = r_t;

    // memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wd;
        r_rd <= mem[r_ra];
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) prod <= r_ma * r_mb;

    logic [3:0] rdaddr;
    always_comb begin
        rdaddr = 4'd0;
        if (r_act == ACT_MUL) rdaddr = 4'(ri) * 4'd3 + 4'(term);
        else if (term == 2'd0) rdaddr = 4'(p) * 4'd3 + 4'(ci);
        else rdaddr = 4'(q) * 4'd3 + 4'(ci);
    end

    always_ff @(posedge i_clk) begin
        r_we <= 1'b0;
        r_cstart <= 1'b0;
        if (!i_rst_n) begin
            r_st <= S_INIT; r_k <= '0; o_valid <= 1'b0;
        end else begin
            case (r_st)
                S_INIT: begin
                    r_we <= 1'b1; r_wa <= r_k;
                    r_wd <= (r_k == 4'd0 || r_k == 4'd4 || r_k == 4'd8) ? ONEV : '0;
                    if (r_k == 4'd8) begin r_st <= S_IDLE; r_k <= '0; end
                    else r_k <= r_k + 4'd1;
                end
                S_IDLE: if (i_valid) begin
                    r_act <= i_action; r_angle <= i_angle; r_k <= '0; r_t <= '0;
                    r_b[0] <= sat_in(i_op_r0c0); r_b[1] <= sat_in(i_op_r0c1);
                    r_b[2] <= sat_in(i_op_r0c2); r_b[3] <= sat_in(i_op_r1c0);
                    r_b[4] <= sat_in(i_op_r1c1); r_b[5] <= sat_in(i_op_r1c2);
                    r_b[6] <= sat_in(i_op_r2c0); r_b[7] <= sat_in(i_op_r2c1);
                    r_b[8] <= sat_in(i_op_r2c2);
                    case (i_action)
                        ACT_ROT_X, ACT_ROT_Y, ACT_ROT_Z: begin
                            r_cstart <= 1'b1; r_st <= S_COR;
                        end
                        ACT_MUL, ACT_IDENT, ACT_TRANS: r_st <= S_RD;
                        default: begin r_st <= S_CPY; end
                    endcase
                end
                S_COR: if (cdone) begin
                    r_s <= csin; r_c <= ccos; r_st <= S_RD;
                end
                // read current entries into result scratch as a base copy
                S_RD: begin
                    r_ra <= r_k;
                    r_m <= 2'd1;
                    r_st <= S_TR;
                end
                S_TR: begin
                    // r_rd holds mem[r_k] once r_m is 2, after r_ra and then r_rd have loaded
                    if (r_m == 2'd1) r_m <= 2'd2;
                    else begin
                        r_res[r_k] <= r_rd;
                        if (r_k == 4'd8) begin
                            r_k <= '0; r_t <= '0; r_acc <= '0; r_m <= '0;
                            r_st <= (r_act == ACT_MUL || r_act == ACT_ROT_X ||
                                r_act == ACT_ROT_Y || r_act == ACT_ROT_Z) ? S_MAC : S_WB;
                        end else begin
                            r_k <= r_k + 4'd1; r_st <= S_RD;
                        end
                    end
                end
                // one product per term: first operand from scratch copy
                S_MAC: begin
                    if (r_act != ACT_MUL && ri != p && ri != q) begin
                        if (r_k == 4'd8) begin r_k <= '0; r_st <= S_CPY; end
                        else r_k <= r_k + 4'd1;
                    end else begin
                        case (r_m)
                            2'd0: begin
                                if (r_act == ACT_MUL) begin
                                    r_ma <= r_res[rdaddr]; r_mb <= r_b[4'(term) * 4'd3 + 4'(ci)];
                                end else begin
                                    r_ma <= r_res[rdaddr];
                                    if (ri == p) r_mb <= (term == 2'd0) ? r_c : r_s;
                                    else r_mb <= (term == 2'd0) ? -r_s : r_c;
                                end
                                r_m <= 2'd1;
                            end
                            2'd1: r_m <= 2'd2;
                            2'd2: begin
                                r_acc <= r_acc + AW'(prod);
                                if (term == ((r_act == ACT_MUL) ? 2'd2 : 2'd1)) begin
                                    r_row <= fin(r_acc + AW'(prod));
                                    r_m <= 2'd3;
                                end else begin
                                    r_t <= r_t + 2'd1;
                                    r_m <= 2'd0;
                                end
                            end
                            // write the finished entry back
                            default: begin
                                r_acc <= '0; r_t <= '0; r_m <= '0;
                                r_we <= 1'b1; r_wa <= r_k; r_wd <= r_row;
                                if (r_k == 4'd8) begin r_k <= '0; r_st <= S_CPY; end
                                else r_k <= r_k + 4'd1;
                            end
                        endcase
                    end
                end
                // identity / transpose write-back
                S_WB: begin
                    r_we <= 1'b1; r_wa <= r_k;
                    if (r_act == ACT_IDENT)
                        r_wd <= (r_k == 4'd0 || r_k == 4'd4 || r_k == 4'd8) ? ONEV : '0;
                    else if (r_act == ACT_TRANS)
                        r_wd <= r_res[4'(ci) * 4'd3 + 4'(ri)];
                    else r_wd <= r_res[r_k];
                    if (r_k == 4'd8) begin r_k <= '0; r_st <= S_CPY; end
                    else r_k <= r_k + 4'd1;
                end
                // read final matrix into output registers
                S_CPY: begin
                    r_ra <= r_k; r_st <= S_HOLD; r_m <= 2'd0;
                end
                S_HOLD: begin
                    if (r_m == 2'd0) r_m <= 2'd1;
                    else begin
                        r_res[r_k] <= r_rd;
                        if (r_k == 4'd8) begin r_st <= S_OUT; o_valid <= 1'b1; end
                        else begin r_k <= r_k + 4'd1; r_st <= S_CPY; end
                    end
                end
                S_OUT: if (!i_stall) begin
                    o_valid <= 1'b0; r_st <= S_IDLE; r_k <= '0;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_out_r0c0 = 32'(r_res[0]); assign o_out_r0c1 = 32'(r_res[1]);
    assign o_out_r0c2 = 32'(r_res[2]); assign o_out_r1c0 = 32'(r_res[3]);
    assign o_out_r1c1 = 32'(r_res[4]); assign o_out_r1c2 = 32'(r_res[5]);
    assign o_out_r2c0 = 32'(r_res[6]); assign o_out_r2c1 = 32'(r_res[7]);
    assign o_out_r2c2 = 32'(r_res[8]);
endmodule
`default_nettype wire
